@@ sv/b_spline_basis_eval_defines.svh @@
// Assertion macros for the b-spline basis evaluator checker.
// No dependencies; the including module must provide clk and rst_n.
`ifndef B_SPLINE_BASIS_EVAL_DEFINES_SVH
`define B_SPLINE_BASIS_EVAL_DEFINES_SVH

// cond must never hold at a clock edge outside reset
`define BSB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// a at one edge implies b at the same edge
`define BSB_IMPLIES(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// a at one edge implies b at the next edge
`define BSB_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

@@ sv/bsb_pkg.sv @@
// Shared sizes, widths and the cell control bundle of the b-spline basis evaluator.
// No dependencies.
package bsb_pkg;

    localparam int FEATURES       = 8;
    localparam int GRID_INTERVALS = 10;
    localparam int ORDER          = 3;

    localparam int NKNOTS     = GRID_INTERVALS + 2 * ORDER + 1;
    localparam int NINTERVALS = NKNOTS - 1;
    localparam int NBASIS     = GRID_INTERVALS + ORDER;

    localparam int KNOT_W    = 16;
    localparam int BASIS_W   = 16;
    localparam int MAG_W     = 16;
    localparam int PROD_W    = 31;
    localparam int DIV_STEPS = PROD_W;
    localparam int ONE_Q15   = 32768;

    localparam int IDX_W  = $clog2(NKNOTS);
    localparam int LVL_W  = $clog2(ORDER + 2);
    localparam int ADDR_W = $clog2(FEATURES * NKNOTS);

    typedef struct packed {
        logic             load_shift;
        logic             set_ind;
        logic             lvl_shift;
        logic             mul;
        logic             div_step;
        logic             finish;
        logic             out_shift;
        logic [LVL_W-1:0] level;
    } cell_ctrl_t;

endpackage

@@ sv/b_spline_basis_eval.sv @@
// Top level of the b-spline basis evaluator: sequencer plus a chain of knot cells.
// Depends on bsb_pkg, bsb_ctrl and bsb_cell.
//
//  channel | role    | tdata (low bit up)                         | tuser  | tlast
//  s_*     | request | feature, knot_index, sample_value          | action | -
//  m_*     | result  | basis_index, basis_value, 4 zero bits      | -      | last
//
// A load request writes a knot to memory. An evaluate request fetches the knots and
// sets the indicators, then runs ORDER levels of recursion through the bit-serial
// dividers in each cell, then sends NBASIS results; a feature out of range gives
// zero bases. Requests wait while an evaluation runs.
// A stalled result holds its data. Reset clears only control state.
module b_spline_basis_eval (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // feature[2:0], knot_index[7:3], sample_value[23:8]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // basis_index[3:0], basis_value[19:4], zero[23:20]
    output logic        m_tlast
);
    import bsb_pkg::*;

    cell_ctrl_t               ctrl;
    logic signed [KNOT_W-1:0] x;
    logic signed [KNOT_W-1:0] knot;
    logic [3:0]               out_idx;
    logic                     zero_out;
    logic signed [KNOT_W-1:0] a_out [NKNOTS];
    logic signed [KNOT_W-1:0] b_out [NKNOTS];
    logic [BASIS_W-1:0]       basis_out [NKNOTS];

    bsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .out_idx  (out_idx),
        .zero_out (zero_out),
        .ctrl     (ctrl),
        .x        (x),
        .knot     (knot)
    );

    // chain of cells, knots enter at the top cell
    for (genvar j = 0; j < NKNOTS; j++)
    begin : g_cell
        logic signed [KNOT_W-1:0] a_nb, b_nb;
        logic [BASIS_W-1:0]       basis_nb;
        if (j == NKNOTS - 1)
        begin : g_top
            assign a_nb     = knot;
            assign b_nb     = knot;
            assign basis_nb = '0;
        end
        else
        begin : g_mid
            assign a_nb     = a_out[j+1];
            assign b_nb     = b_out[j+1];
            assign basis_nb = basis_out[j+1];
        end
        bsb_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .idx       (IDX_W'(j)),
            .x         (x),
            .a_in      (a_nb),
            .b_in      (b_nb),
            .basis_in  (basis_nb),
            .a_out     (a_out[j]),
            .b_out     (b_out[j]),
            .basis_out (basis_out[j])
        );
    end

    assign m_tdata = {4'b0, (zero_out ? {BASIS_W{1'b0}} : basis_out[0]), out_idx};

endmodule

@@ sv/bsb_cell.sv @@
// One knot cell of the evaluator chain: knot pair, basis, two serial dividers.
// Depends on bsb_pkg.
module bsb_cell (
    input  logic                                clk,
    input  bsb_pkg::cell_ctrl_t                 ctrl,
    input  logic [bsb_pkg::IDX_W-1:0]           idx,
    input  logic signed [bsb_pkg::KNOT_W-1:0]   x,
    input  logic signed [bsb_pkg::KNOT_W-1:0]   a_in,
    input  logic signed [bsb_pkg::KNOT_W-1:0]   b_in,
    input  logic [bsb_pkg::BASIS_W-1:0]         basis_in,
    output logic signed [bsb_pkg::KNOT_W-1:0]   a_out,
    output logic signed [bsb_pkg::KNOT_W-1:0]   b_out,
    output logic [bsb_pkg::BASIS_W-1:0]         basis_out
);
    import bsb_pkg::*;

    logic signed [KNOT_W-1:0] a_reg;
    logic signed [KNOT_W-1:0] b_reg;
    logic [BASIS_W-1:0]       basis_reg;
    logic                     active_reg;
    logic                     zero1_reg, zero2_reg;
    logic                     neg1_reg, neg2_reg;
    logic [MAG_W-1:0]         d1_reg, d2_reg;
    logic [MAG_W-1:0]         r1_reg, r2_reg;
    logic [PROD_W-1:0]        q1_reg, q2_reg;

    logic signed [KNOT_W:0]   num1, den1, num2, den2;
    logic [2*MAG_W-1:0]       p1, p2;
    logic                     act;
    logic [MAG_W:0]           t1, t2;
    logic                     ge1, ge2;
    logic [MAG_W:0]           df1, df2;
    logic signed [PROD_W+1:0] term1, term2;
    logic signed [PROD_W+2:0] sum;
    logic [BASIS_W-1:0]       clamped;

    function automatic logic [MAG_W-1:0] mag(input logic signed [KNOT_W:0] v);
        logic [KNOT_W:0] u;
        u = v[KNOT_W] ? -v : v;
        return u[MAG_W-1:0];
    endfunction

    // differences: a = t[j], a_in = t[j+1], b = t[j+k], b_in = t[j+k+1]
    always_comb
    begin
        num1 = (KNOT_W+1)'(x) - (KNOT_W+1)'(a_reg);
        den1 = (KNOT_W+1)'(b_reg) - (KNOT_W+1)'(a_reg);
        num2 = (KNOT_W+1)'(b_in) - (KNOT_W+1)'(x);
        den2 = (KNOT_W+1)'(b_in) - (KNOT_W+1)'(a_in);
        p1   = (2*MAG_W)'(mag(num1)) * (2*MAG_W)'(basis_reg);
        p2   = (2*MAG_W)'(mag(num2)) * (2*MAG_W)'(basis_in);
        act  = (int'(idx) + int'(ctrl.level)) < NINTERVALS;
    end

    // one restoring division step per term
    always_comb
    begin
        t1  = {r1_reg, q1_reg[PROD_W-1]};
        t2  = {r2_reg, q2_reg[PROD_W-1]};
        ge1 = t1 >= {1'b0, d1_reg};
        ge2 = t2 >= {1'b0, d2_reg};
        df1 = t1 - {1'b0, d1_reg};
        df2 = t2 - {1'b0, d2_reg};
    end

    // signed terms, sum and clamp to [0, 1.0]
    always_comb
    begin
        term1 = zero1_reg ? '0 : (neg1_reg ? -(PROD_W+2)'(q1_reg) : (PROD_W+2)'(q1_reg));
        term2 = zero2_reg ? '0 : (neg2_reg ? -(PROD_W+2)'(q2_reg) : (PROD_W+2)'(q2_reg));
        sum   = (PROD_W+3)'(term1) + (PROD_W+3)'(term2);
        if (sum < 0)
        begin
            clamped = '0;
        end
        else if (sum > ONE_Q15)
        begin
            clamped = BASIS_W'(ONE_Q15);
        end
        else
        begin
            clamped = sum[BASIS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        // shift knots in from the upper neighbor
        if (ctrl.load_shift)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
        // set order-0 indicator
        if (ctrl.set_ind)
        begin
            basis_reg <= (x >= a_reg && x < a_in) ? BASIS_W'(ONE_Q15) : '0;
        end
        // advance upper knot by one position per level
        if (ctrl.lvl_shift)
        begin
            b_reg <= b_in;
        end
        // form products and divisors
        if (ctrl.mul)
        begin
            active_reg <= act;
            zero1_reg  <= den1 == '0;
            zero2_reg  <= den2 == '0;
            neg1_reg   <= num1[KNOT_W] ^ den1[KNOT_W];
            neg2_reg   <= num2[KNOT_W] ^ den2[KNOT_W];
            d1_reg     <= mag(den1);
            d2_reg     <= mag(den2);
            r1_reg     <= '0;
            r2_reg     <= '0;
            q1_reg     <= p1[PROD_W-1:0];
            q2_reg     <= p2[PROD_W-1:0];
        end
        if (ctrl.div_step)
        begin
            r1_reg <= ge1 ? df1[MAG_W-1:0] : t1[MAG_W-1:0];
            r2_reg <= ge2 ? df2[MAG_W-1:0] : t2[MAG_W-1:0];
            q1_reg <= {q1_reg[PROD_W-2:0], ge1};
            q2_reg <= {q2_reg[PROD_W-2:0], ge2};
        end
        if (ctrl.finish && active_reg)
        begin
            basis_reg <= clamped;
        end
        // drain bases toward cell zero
        if (ctrl.out_shift)
        begin
            basis_reg <= basis_in;
        end
    end

    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign basis_out = basis_reg;

endmodule

@@ sv/bsb_ctrl.sv @@
// Sequencer and knot memory of the b-spline basis evaluator.
// Depends on bsb_pkg.
module bsb_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic                              m_tlast,
    output logic [3:0]                        out_idx,
    output logic                              zero_out,
    output bsb_pkg::cell_ctrl_t               ctrl,
    output logic signed [bsb_pkg::KNOT_W-1:0] x,
    output logic signed [bsb_pkg::KNOT_W-1:0] knot
);
    import bsb_pkg::*;

    localparam int FCNT_W = $clog2(NKNOTS + 1);
    localparam int DCNT_W = $clog2(DIV_STEPS);
    localparam int OCNT_W = $clog2(NBASIS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_IND, S_LSHIFT, S_MUL, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t              state_reg;
    logic [FCNT_W-1:0]   fetch_cnt_reg;
    logic [DCNT_W-1:0]   div_cnt_reg;
    logic [LVL_W-1:0]    level_reg;
    logic [OCNT_W-1:0]   out_cnt_reg;
    logic                zero_reg;
    logic [2:0]          feat_reg;
    logic signed [KNOT_W-1:0] x_reg;
    logic signed [KNOT_W-1:0] rd_data_reg;
    logic [KNOT_W-1:0]   mem [FEATURES*NKNOTS];

    logic                acc;
    logic                act;
    logic [2:0]          feature;
    logic [4:0]          kidx;
    logic [KNOT_W-1:0]   sample;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic                out_done;

    assign act      = s_tuser;
    assign feature  = s_tdata[2:0];
    assign kidx     = s_tdata[7:3];
    assign sample   = s_tdata[23:8];
    assign s_tready = state_reg == S_IDLE;
    assign acc      = s_tvalid && s_tready;
    assign wr_addr  = ADDR_W'(feature) * ADDR_W'(NKNOTS) + ADDR_W'(kidx);
    assign rd_addr  = ADDR_W'(feat_reg) * ADDR_W'(NKNOTS) + ADDR_W'(fetch_cnt_reg);
    assign out_done = m_tready && out_cnt_reg == OCNT_W'(NBASIS - 1);

    // knot memory: write on load request, read one knot a cycle while fetching
    always_ff @(posedge clk)
    begin
        if (acc && !act && int'(kidx) < NKNOTS && int'(feature) < FEATURES)
        begin
            mem[wr_addr] <= sample;
        end
        if (state_reg == S_FETCH && int'(fetch_cnt_reg) < NKNOTS)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // hold sample and feature of the evaluate request
    always_ff @(posedge clk)
    begin
        if (acc && act)
        begin
            x_reg    <= sample;
            feat_reg <= feature;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fetch_cnt_reg <= '0;
            div_cnt_reg   <= '0;
            level_reg     <= '0;
            out_cnt_reg   <= '0;
            zero_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (acc && act)
                    begin
                        fetch_cnt_reg <= '0;
                        level_reg     <= '0;
                        out_cnt_reg   <= '0;
                        zero_reg      <= int'(feature) >= FEATURES;
                        state_reg     <= (int'(feature) >= FEATURES) ? S_OUT : S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    fetch_cnt_reg <= fetch_cnt_reg + 1'b1;
                    if (fetch_cnt_reg == FCNT_W'(NKNOTS))
                    begin
                        state_reg <= S_IND;
                    end
                end
                S_IND:
                begin
                    state_reg <= (ORDER == 0) ? S_OUT : S_LSHIFT;
                end
                S_LSHIFT:
                begin
                    level_reg <= level_reg + 1'b1;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg <= (level_reg == LVL_W'(ORDER)) ? S_OUT : S_LSHIFT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        out_cnt_reg <= out_cnt_reg + 1'b1;
                    end
                    if (out_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // decode cell controls from the state
    always_comb
    begin
        ctrl            = '0;
        ctrl.load_shift = state_reg == S_FETCH && fetch_cnt_reg != '0;
        ctrl.set_ind    = state_reg == S_IND;
        ctrl.lvl_shift  = state_reg == S_LSHIFT;
        ctrl.mul        = state_reg == S_MUL;
        ctrl.div_step   = state_reg == S_DIV;
        ctrl.finish     = state_reg == S_FIN;
        ctrl.out_shift  = state_reg == S_OUT && m_tready;
        ctrl.level      = level_reg;
    end

    assign m_tvalid = state_reg == S_OUT;
    assign m_tlast  = out_cnt_reg == OCNT_W'(NBASIS - 1);
    assign out_idx  = 4'(out_cnt_reg);
    assign zero_out = zero_reg;
    assign x        = x_reg;
    assign knot     = rd_data_reg;

endmodule

@@ sv/bsb_checker.sv @@
// Port-level checks of the b-spline basis evaluator, bound to the top level.
// Depends on b_spline_basis_eval_defines.svh.
`include "b_spline_basis_eval_defines.svh"

module bsb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    // a stalled result holds
    `BSB_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    // no new request taken while results drain
    `BSB_NEVER(a_excl, s_tready && m_tvalid, "request accepted during result phase")
    // after the final basis the block returns to idle
    `BSB_NEXT(a_end, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "no idle after last basis")
    // basis stays within one and padding is zero
    `BSB_IMPLIES(a_range, m_tvalid, m_tdata[19:4] <= 16'h8000 && m_tdata[23:20] == 4'b0, "basis out of range")

endmodule

bind b_spline_basis_eval bsb_checker u_bsb_checker (.*);
